// File: hw/rtl/rrwt_pkg.sv
// Package for the round-robin wait time engine: payload structs, shared widths
// and the command and status structs between controller and datapath.
// Has no dependencies.
`default_nettype none

package rrwt_pkg;

  localparam int TIME_W         = 22;
  localparam int SLICE_W        = 8;
  localparam int IDX_OUT_W      = 5;
  localparam int BURST_IN_W     = 16;
  localparam int MAX_PROCS_DEF  = 32;
  localparam int BURST_BITS_DEF = 16;
  localparam logic [SLICE_W-1:0] RESET_SLICE = SLICE_W'(2);

  typedef struct packed {
    logic [BURST_IN_W-1:0] burst_time;
    logic                  last_process;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] process_index;
    logic [TIME_W-1:0]    waiting_time;
    logic [TIME_W-1:0]    turnaround_time;
    logic                 last_result;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic serve_start;
    logic rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic finish;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/rrwt_ctrl.sv
// Controller state machine of the round-robin wait time engine.
// Depends on rrwt_pkg for the command and status structs.
`default_nettype none

module rrwt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          last_process,
  output logic               busy,
  output rrwt_pkg::cmd_t     cmd,
  input  wire rrwt_pkg::sts_t sts
);
  import rrwt_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;

  always_comb begin
    state_nxt       = state_r;
    cmd.load        = 1'b0;
    cmd.serve_start = 1'b0;
    cmd.rd          = 1'b0;
    cmd.exec        = 1'b0;
    case (state_r)
      ST_LOAD: begin
        cmd.load        = accept;
        cmd.serve_start = accept && last_process;
        if (accept && last_process) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.finish ? ST_LOAD : ST_READ;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_serves: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_process |=> state_r == ST_READ)
    else $error("serving did not begin after the final transaction");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.finish |=> !busy)
    else $error("engine still busy after the last completion");
  a_finish_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    sts.finish |-> cmd.exec)
    else $error("completion reported outside an update cycle");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rrwt_datapath.sv
// Datapath of the round-robin wait time engine: process table memory, time
// and count registers, slice register and result register. Depends on rrwt_pkg.
`default_nettype none

module rrwt_datapath #(
  parameter int MAX_PROCS  = rrwt_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = rrwt_pkg::BURST_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rrwt_pkg::in_item_t          in_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rrwt_pkg::SLICE_W-1:0] cfg_wr_data,
  input  wire rrwt_pkg::cmd_t              cmd,
  output rrwt_pkg::sts_t                   sts,
  output logic                             out_valid,
  output rrwt_pkg::out_item_t              out_data
);
  import rrwt_pkg::*;

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int WORD_W = 2 * BURST_BITS + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  logic [WORD_W-1:0]     mem [MAX_PROCS];
  logic [WORD_W-1:0]     rd_q;

  logic [SLICE_W-1:0]    slice_r;
  logic [TIME_W-1:0]     time_r;
  logic [CNT_W-1:0]      loaded_r;
  logic [CNT_W-1:0]      unfinished_r;
  logic [IDX_W-1:0]      scan_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [BURST_BITS+BURST_IN_W-1:0] burst_ext;
  logic [BURST_BITS-1:0]            burst_in;
  logic                             load_wr;
  logic [CNT_W-1:0]                 loaded_inc;

  logic                             rd_done;
  logic [BURST_BITS-1:0]            rd_burst;
  logic [BURST_BITS-1:0]            rd_rem;
  logic [SLICE_W-1:0]               slice_eff;
  logic [BURST_BITS+SLICE_W-1:0]    rem_cmp, slice_cmp;
  logic                             fits;
  logic [BURST_BITS+TIME_W-1:0]     rem_wide, burst_wide;
  logic [SLICE_W+TIME_W-1:0]        slice_wide;
  logic [TIME_W-1:0]                time_add, time_nxt, wait_time;
  logic [BURST_BITS-1:0]            rem_nxt;
  logic                             complete;
  logic [IDX_W+IDX_OUT_W-1:0]       idx_wide;
  logic [IDX_W-1:0]                 scan_inc;

  assign burst_ext  = {{BURST_BITS{1'b0}}, in_data.burst_time};
  assign burst_in   = burst_ext[BURST_BITS-1:0];
  assign load_wr    = cmd.load && (loaded_r < CNT_MAX);
  assign loaded_inc = loaded_r + CNT_W'(1);

  assign rd_done    = rd_q[WORD_W-1];
  assign rd_burst   = rd_q[2*BURST_BITS-1:BURST_BITS];
  assign rd_rem     = rd_q[BURST_BITS-1:0];
  assign slice_eff  = (slice_r == '0) ? SLICE_W'(1) : slice_r;
  assign rem_cmp    = {{SLICE_W{1'b0}}, rd_rem};
  assign slice_cmp  = {{BURST_BITS{1'b0}}, slice_eff};
  assign fits       = (rem_cmp <= slice_cmp);
  assign rem_wide   = {{TIME_W{1'b0}}, rd_rem};
  assign burst_wide = {{TIME_W{1'b0}}, rd_burst};
  assign slice_wide = {{TIME_W{1'b0}}, slice_eff};
  assign time_add   = fits ? rem_wide[TIME_W-1:0] : slice_wide[TIME_W-1:0];
  assign time_nxt   = time_r + time_add;
  assign wait_time  = time_nxt - burst_wide[TIME_W-1:0];
  assign rem_nxt    = fits ? '0 : (rd_rem - slice_cmp[BURST_BITS-1:0]);
  assign complete   = cmd.exec && !rd_done && fits;
  assign sts.finish = complete && (unfinished_r == CNT_W'(1));
  assign idx_wide   = {{IDX_OUT_W{1'b0}}, scan_r};
  assign scan_inc   = scan_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem[loaded_r[IDX_W-1:0]] <= {1'b0, burst_in, burst_in};
    end else if (cmd.exec && !rd_done) begin
      mem[scan_r] <= {fits, rd_burst, rem_nxt};
    end
    if (cmd.rd) begin
      rd_q <= mem[scan_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r      <= RESET_SLICE;
      time_r       <= '0;
      loaded_r     <= '0;
      unfinished_r <= '0;
      scan_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slice_r <= cfg_wr_data;
      end
      if (load_wr) begin
        loaded_r <= loaded_inc;
      end
      if (cmd.serve_start) begin
        time_r       <= '0;
        scan_r       <= '0;
        unfinished_r <= load_wr ? loaded_inc : loaded_r;
      end
      if (cmd.exec) begin
        if (!rd_done) begin
          time_r <= time_nxt;
        end
        if (complete) begin
          unfinished_r <= unfinished_r - CNT_W'(1);
        end
        if (sts.finish) begin
          scan_r   <= '0;
          loaded_r <= '0;
        end else if (CNT_W'(scan_inc) == loaded_r || scan_inc == '0) begin
          scan_r <= '0;
        end else begin
          scan_r <= scan_inc;
        end
      end
      out_valid_r <= complete;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      out_r.process_index   <= idx_wide[IDX_OUT_W-1:0];
      out_r.waiting_time    <= wait_time;
      out_r.turnaround_time <= time_nxt;
      out_r.last_result     <= sts.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.exec))
    else $error("result transaction without a preceding table update");
  a_work_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> unfinished_r != '0)
    else $error("table update with no unfinished process");
  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    sts.finish |=> loaded_r == '0 && out_valid_r && out_r.last_result)
    else $error("final completion did not clear the set");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/round_robin_wait_time_engine_core.sv
// Top level of the round-robin wait time engine: controller and datapath.
// Depends on rrwt_pkg, rrwt_ctrl and rrwt_datapath.
//
//   Channel  Ports                       Handshake
//   input    start, busy, in_data        taken when start is high and busy is low
//   result   out_valid, out_data         one cycle per transaction, no back-pressure
//   config   cfg_wr_en, cfg_wr_data      written on any edge with cfg_wr_en high
//
// Processes are loaded one per cycle while busy is low. On the final transaction the
// engine serves the table, visiting each entry with a registered memory read and then
// an update. Every round visits all loaded entries, finished ones included, and busy
// holds the input off until the update of the final completion.
// Results appear in the cycle after the update that completes a process.
// Reset is synchronous and active low; the table memory is not cleared.
`default_nettype none

module round_robin_wait_time_engine_core #(
  parameter int MAX_PROCS  = rrwt_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = rrwt_pkg::BURST_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire rrwt_pkg::in_item_t           in_data,
  output logic                              out_valid,
  output rrwt_pkg::out_item_t               out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rrwt_pkg::SLICE_W-1:0] cfg_wr_data
);
  import rrwt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrwt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .last_process (in_data.last_process),
    .busy         (busy),
    .cmd          (cmd),
    .sts          (sts)
  );

  rrwt_datapath #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// File: bench/round_robin_wait_time_checker.sv
`timescale 1ns / 100ps
// Checker for the round-robin wait time engine: follows the load, result and
// configuration ports, predicts every completion of a set and compares it.
// Depends on rrwt_pkg only.
module round_robin_wait_time_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  rrwt_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  rrwt_pkg::out_item_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [rrwt_pkg::SLICE_W-1:0] cfg_wr_data,
  output int                           mismatch_count,
  output int                           outstanding
);
  localparam int TABLE_DEPTH = rrwt_pkg::MAX_PROCS_DEF;
  localparam int TW          = rrwt_pkg::TIME_W;
  localparam int IW          = rrwt_pkg::IDX_OUT_W;

  logic [rrwt_pkg::BURST_IN_W-1:0] burst_table [TABLE_DEPTH];
  logic [rrwt_pkg::SLICE_W-1:0]    slice_reg = rrwt_pkg::RESET_SLICE;
  int                              loaded = 0;
  int                              fail_total = 0;
  rrwt_pkg::out_item_t             completions_q [$];

  task automatic serve_table();
    int                  left [TABLE_DEPTH];
    bit                  done [TABLE_DEPTH];
    int                  quantum;
    int                  unfinished;
    logic [TW-1:0]       now;
    rrwt_pkg::out_item_t item;
    quantum    = (slice_reg == '0) ? 1 : int'(slice_reg);
    unfinished = loaded;
    now        = '0;
    for (int p = 0; p < loaded; p++) begin
      left[p] = int'(burst_table[p]);
      done[p] = 1'b0;
    end
    // Processes are visited in load order, round after round, until all are done.
    while (unfinished > 0) begin
      for (int p = 0; p < loaded; p++) begin
        if (!done[p]) begin
          if (left[p] <= quantum) begin
            now                  = now + TW'(left[p]);
            done[p]              = 1'b1;
            unfinished--;
            item.process_index   = IW'(p);
            item.waiting_time    = now - TW'(burst_table[p]);
            item.turnaround_time = now;
            item.last_result     = (unfinished == 0);
            completions_q.push_back(item);
          end else begin
            now     = now + TW'(quantum);
            left[p] = left[p] - quantum;
          end
        end
      end
    end
    loaded = 0;
  endtask

  task automatic log_discrepancy(input string what, input rrwt_pkg::out_item_t want,
                                 input rrwt_pkg::out_item_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t: %s: expected idx %0d wait %0d tat %0d last %0b, got idx %0d wait %0d tat %0d last %0b",
               $time, what, want.process_index, want.waiting_time, want.turnaround_time,
               want.last_result, got.process_index, got.waiting_time, got.turnaround_time,
               got.last_result);
    end
  endtask

  always @(posedge clk) begin
    rrwt_pkg::out_item_t want;
    if (!rst_n) begin
      loaded    = 0;
      slice_reg = rrwt_pkg::RESET_SLICE;
      completions_q.delete();
    end else begin
      if (cfg_wr_en) begin
        slice_reg = cfg_wr_data;
      end
      if (start && !busy) begin
        // A burst beyond the table capacity is dropped, but its flag still counts.
        if (loaded < TABLE_DEPTH) begin
          burst_table[loaded] = in_data.burst_time;
          loaded++;
        end
        if (in_data.last_process) begin
          serve_table();
        end
      end
      if (out_valid) begin
        if (completions_q.size() == 0) begin
          log_discrepancy("unexpected completion", '0, out_data);
        end else begin
          want = completions_q.pop_front();
          if (out_data.process_index !== want.process_index ||
              out_data.waiting_time !== want.waiting_time ||
              out_data.turnaround_time !== want.turnaround_time ||
              out_data.last_result !== want.last_result) begin
            log_discrepancy("completion differs", want, out_data);
          end
        end
      end
    end
    outstanding    <= completions_q.size();
    mismatch_count <= fail_total;
  end

endmodule

// File: bench/round_robin_wait_time_engine_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the round-robin wait time engine: clock, reset, transaction
// stimulus and the verdict. Depends on rrwt_pkg, the engine and the checker.
module round_robin_wait_time_engine_core_tb;
  localparam int DIRECTED_ITEMS = 14;
  localparam int RANDOM_ITEMS   = 410;
  localparam int SETTLE_CYCLES  = 8;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  rrwt_pkg::in_item_t           in_data;
  logic                         out_valid;
  rrwt_pkg::out_item_t          out_data;
  logic                         cfg_wr_en;
  logic [rrwt_pkg::SLICE_W-1:0] cfg_wr_data;
  int                           mismatch_count;
  int                           outstanding;
  int                           items_sent;
  int                           idle_pct;
  logic [rrwt_pkg::SLICE_W-1:0] slice_now;

  round_robin_wait_time_engine_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  round_robin_wait_time_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic send_burst(input logic [15:0] burst, input logic last_flag);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= {burst, last_flag};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slice(input logic [rrwt_pkg::SLICE_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slice_now = value;
  endtask

  function automatic logic [15:0] pick_burst();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'd0;
    // Large bursts only where the slice keeps the number of turns modest.
    if (roll < 14 && slice_now >= 32) return 16'($urandom_range(65535));
    if (roll < 30 && slice_now > 1) return 16'(slice_now) + 16'($urandom_range(2)) - 16'd1;
    return 16'($urandom_range(1, 40));
  endfunction

  function automatic logic [rrwt_pkg::SLICE_W-1:0] pick_slice();
    case ($urandom_range(3))
      0:       return 8'd1;
      1:       return 8'd255;
      2:       return rrwt_pkg::RESET_SLICE;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic random_set(input int len);
    for (int p = 0; p < len; p++) begin
      send_burst(pick_burst(), p == len - 1);
    end
  endtask

  initial begin
    int phase_idx;
    start       <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    idle_pct   = 0;
    items_sent = 0;
    slice_now  = rrwt_pkg::RESET_SLICE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first set runs with the slice left at its reset value.
    send_burst(16'd5, 1'b0);
    send_burst(16'd0, 1'b0);
    send_burst(16'd3, 1'b0);
    send_burst(16'd1, 1'b1);
    write_slice(8'd255);
    send_burst(16'hFFFF, 1'b0);
    send_burst(16'd255, 1'b0);
    send_burst(16'd256, 1'b1);
    write_slice(8'd1);
    send_burst(16'd1, 1'b0);
    send_burst(16'd0, 1'b0);
    send_burst(16'd2, 1'b0);
    send_burst(16'd0, 1'b1);
    // A zero slice behaves as a slice of one.
    write_slice(8'd0);
    send_burst(16'd3, 1'b0);
    send_burst(16'd2, 1'b1);
    send_burst(16'd0, 1'b1);

    for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
      idle_pct = (phase_idx == 0) ? 20 : (phase_idx == 1) ? 62 : 0;
      write_slice(pick_slice());
      if (phase_idx == 0) begin
        random_set(34);
      end
      while (items_sent < DIRECTED_ITEMS + (phase_idx + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(99) < 25) begin
          write_slice(pick_slice());
        end else if ($urandom_range(99) < 10) begin
          settle();
        end
        random_set(($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8));
      end
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
